>>> rtl/sector_buffer_cache_lru_unit_defines.svh
// Assertion macros for the sector buffer cache RTL, used by the sequencer.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef SECTOR_BUFFER_CACHE_LRU_UNIT_DEFINES_SVH
`define SECTOR_BUFFER_CACHE_LRU_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCB_ASSERT(lbl, prop, msg)
`define SCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/scb_pkg.sv
// Package for the sector buffer cache: word types, codes and defaults.
// Used by the top level, the sequencer and the datapath; depends on nothing.
`timescale 1ns / 1ps
package scb_pkg;

  localparam int CACHE_ENTRIES_DEF    = 64;
  localparam int SECTOR_WORDS_DEF     = 64;
  localparam int SECTOR_ADDR_BITS_DEF = 24;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;
  localparam logic [1:0] KIND_FLUSH = 2'd3;

  localparam logic [2:0] RESP_READ  = 3'd0;
  localparam logic [2:0] RESP_WRITE = 3'd1;
  localparam logic [2:0] RESP_DISK  = 3'd2;
  localparam logic [2:0] RESP_FLUSH = 3'd3;
  localparam logic [2:0] RESP_ERROR = 3'd4;

  localparam logic REG_DISK_SECTORS = 1'b0;
  localparam logic REG_ENTRIES      = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] sector;
    logic [5:0]  word_index;
    logic [63:0] data_in;
    logic [7:0]  byte_enable;
  } in_t;

  typedef struct packed {
    logic [2:0]  resp_kind;
    logic [63:0] data_out;
    logic [23:0] disk_sector;
    logic [5:0]  out_word;
    logic        fetch_request;
    logic [23:0] fetch_sector;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [24:0] disk_sectors;
    logic [6:0]  entries_in_use;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SCAN, OP_ERR, OP_FLUSH_ALL, OP_SEL_DIRTY, OP_SEL_VICTIM,
    OP_HIT, OP_ALLOC_FETCH, OP_ALLOC, OP_CLR_DIRTY, OP_WB, OP_FILL_WR, OP_FILL_DONE,
    OP_ACC_RD, OP_ACC_DONE
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       pend_on;
    logic       oor;
    logic       scan_done;
    logic       hit;
    logic       dfound;
    logic       vdirty;
    logic       fill_last;
    logic       wb_done;
  } sts_t;

endpackage

>>> rtl/scb_ram.sv
// Generic single write port RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module scb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> rtl/scb_ctrl.sv
// Sequencer of the sector buffer cache: one item at a time.
// Depends on scb_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sector_buffer_cache_lru_unit_defines.svh"
module scb_ctrl import scb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN, ST_DECIDE, ST_VCHK, ST_WB, ST_FILL_DONE,
    ST_ACC_ADDR, ST_ACC_USE
  } state_e;

  state_e st_q, st_d;
  op_e    op;
  logic   is_flush;

  assign is_flush = (sts_i.kind == KIND_FLUSH);

  always_comb begin
    st_d = st_q;
    op   = OP_NONE;
    case (st_q)
      ST_IDLE: begin
        if (start_i) begin
          op   = OP_LOAD;
          st_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts_i.kind == KIND_FILL) begin
          if (!sts_i.pend_on) begin
            st_d = ST_IDLE;
          end else begin
            op   = OP_FILL_WR;
            st_d = sts_i.fill_last ? ST_FILL_DONE : ST_IDLE;
          end
        end else if (sts_i.pend_on || (!is_flush && sts_i.oor)) begin
          op   = OP_ERR;
          st_d = ST_IDLE;
        end else begin
          st_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          st_d = ST_DECIDE;
        end else begin
          op = OP_SCAN;
        end
      end
      ST_DECIDE: begin
        if (is_flush) begin
          if (sts_i.dfound) begin
            op   = OP_SEL_DIRTY;
            st_d = ST_WB;
          end else begin
            op   = OP_FLUSH_ALL;
            st_d = ST_IDLE;
          end
        end else if (sts_i.hit) begin
          op   = OP_HIT;
          st_d = ST_ACC_ADDR;
        end else begin
          op   = OP_SEL_VICTIM;
          st_d = ST_VCHK;
        end
      end
      ST_VCHK: begin
        if (sts_i.vdirty) begin
          st_d = ST_WB;
        end else begin
          op   = OP_ALLOC_FETCH;
          st_d = ST_IDLE;
        end
      end
      ST_WB: begin
        if (sts_i.wb_done) begin
          op   = is_flush ? OP_CLR_DIRTY : OP_ALLOC;
          st_d = ST_IDLE;
        end else begin
          op = OP_WB;
        end
      end
      ST_FILL_DONE: begin
        op   = OP_FILL_DONE;
        st_d = ST_ACC_ADDR;
      end
      ST_ACC_ADDR: begin
        op   = OP_ACC_RD;
        st_d = ST_ACC_USE;
      end
      ST_ACC_USE: begin
        op   = OP_ACC_DONE;
        st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  assign busy_o    = (st_q != ST_IDLE);
  assign cmd_o.op  = op;

  `SCB_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, st_q == ST_DISPATCH, "accept lost")
  `SCB_ASSERT_NEXT(a_wb_holds, st_q == ST_WB && !sts_i.wb_done, st_q == ST_WB, "wb cut short")
  `SCB_ASSERT_NEXT(a_acc_ends, st_q == ST_ACC_USE, st_q == ST_IDLE, "access did not end")
endmodule

>>> rtl/scb_dp.sv
// Datapath of the sector buffer cache: tag, stamp and line RAMs, entry flags,
// scan and write-back counters, pending access and the result register.
// Depends on scb_pkg and scb_ram.
`timescale 1ns / 1ps
module scb_dp import scb_pkg::*; #(
  parameter int CACHE_ENTRIES    = CACHE_ENTRIES_DEF,
  parameter int SECTOR_WORDS     = SECTOR_WORDS_DEF,
  parameter int SECTOR_ADDR_BITS = SECTOR_ADDR_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output out_t result_o,
  output logic res_strobe_o
);
  localparam int EB  = $clog2(CACHE_ENTRIES);
  localparam int CB  = $clog2(CACHE_ENTRIES + 1);
  localparam int WB  = $clog2(SECTOR_WORDS);
  localparam int WC  = $clog2(SECTOR_WORDS + 1);
  localparam int LA  = $clog2(CACHE_ENTRIES * SECTOR_WORDS);
  localparam int SAB = SECTOR_ADDR_BITS;

  function automatic logic [WB-1:0] wmod(input logic [5:0] v);
    logic [9:0] t;
    t = {4'b0, v};
    for (int k = 0; k < 8; k++) begin
      if (t >= 10'(SECTOR_WORDS)) t = t - 10'(SECTOR_WORDS);
    end
    return WB'(t);
  endfunction

  function automatic logic [LA-1:0] laddr(input logic [EB-1:0] e, input logic [WB-1:0] w);
    return LA'(e) * LA'(SECTOR_WORDS) + LA'(w);
  endfunction

  // Control state.
  logic [CACHE_ENTRIES-1:0] val_q, val_d, dty_q, dty_d;
  logic [31:0]   clk_q, clk_d;
  logic          pend_on_q, pend_on_d;
  logic [EB-1:0] ft_q, ft_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic          scan_v_q, scan_v_d;
  logic [WC-1:0] wcnt_q, wcnt_d;
  logic          wb_v_q, wb_v_d;
  logic          hit_q, hit_d, free_q, free_d, dfound_q, dfound_d;
  logic          stb_q, stb_d;
  // Payload.
  in_t           it_q, it_d;
  logic          pk_q, pk_d;
  logic [WB-1:0] pw_q, pw_d;
  logic [63:0]   pd_q, pd_d;
  logic [7:0]    pb_q, pb_d;
  logic [EB-1:0] tgt_q, tgt_d, sidx_q, sidx_d, hidx_q, hidx_d, fidx_q, fidx_d;
  logic [EB-1:0] lidx_q, lidx_d, didx_q, didx_d;
  logic [31:0]   lstamp_q, lstamp_d;
  logic [WB-1:0] wb_w_q, wb_w_d;
  logic          wb_fr_q, wb_fr_d;
  out_t          res_q, res_d;

  logic [SAB-1:0] sec, tag_rd, tag_wdata;
  logic [31:0]    stamp_rd;
  logic [63:0]    line_rd, merged, mask;
  logic [WB-1:0]  wi;
  logic [CB-1:0]  lim;
  logic           tag_we, stamp_we, line_we, wl;
  logic [EB-1:0]  tag_raddr, stamp_waddr;
  logic [LA-1:0]  line_waddr, line_raddr;
  logic [63:0]    line_wdata;
  op_e            op;

  assign op  = cmd_i.op;
  assign sec = SAB'(it_q.sector);
  assign wi  = wmod(it_q.word_index);

  always_comb begin
    if (cfg_i.entries_in_use == 7'd0) begin
      lim = CB'(1);
    end else if (32'(cfg_i.entries_in_use) > 32'(CACHE_ENTRIES)) begin
      lim = CB'(CACHE_ENTRIES);
    end else begin
      lim = CB'(cfg_i.entries_in_use);
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) mask[8*b +: 8] = {8{pb_q[b]}};
    merged = (line_rd & ~mask) | (pd_q & mask);
  end

  // RAM ports.
  assign tag_we      = (op == OP_ALLOC) || (op == OP_ALLOC_FETCH);
  assign tag_wdata   = sec;
  assign tag_raddr   = (op == OP_SCAN) ? cnt_q[EB-1:0] : tgt_q;
  assign stamp_we    = (op == OP_HIT) || (op == OP_FILL_DONE);
  assign stamp_waddr = (op == OP_HIT) ? hidx_q : ft_q;
  assign line_we     = (op == OP_FILL_WR) || ((op == OP_ACC_DONE) && pk_q);
  assign line_waddr  = (op == OP_FILL_WR) ? laddr(ft_q, wi) : laddr(tgt_q, pw_q);
  assign line_wdata  = (op == OP_FILL_WR) ? it_q.data_in : merged;
  assign line_raddr  = (op == OP_WB) ? laddr(tgt_q, WB'(wcnt_q)) : laddr(tgt_q, pw_q);

  scb_ram #(.WIDTH(SAB), .DEPTH(CACHE_ENTRIES)) u_tag (
    .clk_i, .we_i(tag_we), .waddr_i(tgt_q), .wdata_i(tag_wdata),
    .raddr_i(tag_raddr), .rdata_o(tag_rd)
  );
  scb_ram #(.WIDTH(32), .DEPTH(CACHE_ENTRIES)) u_stamp (
    .clk_i, .we_i(stamp_we), .waddr_i(stamp_waddr), .wdata_i(clk_q),
    .raddr_i(cnt_q[EB-1:0]), .rdata_o(stamp_rd)
  );
  scb_ram #(.WIDTH(64), .DEPTH(CACHE_ENTRIES * SECTOR_WORDS)) u_line (
    .clk_i, .we_i(line_we), .waddr_i(line_waddr), .wdata_i(line_wdata),
    .raddr_i(line_raddr), .rdata_o(line_rd)
  );

  assign wl = (wb_w_q == WB'(SECTOR_WORDS - 1));

  always_comb begin
    val_d = val_q;  dty_d = dty_q;  clk_d = clk_q;  pend_on_d = pend_on_q;
    ft_d = ft_q;  cnt_d = cnt_q;  scan_v_d = 1'b0;  wcnt_d = wcnt_q;  wb_v_d = 1'b0;
    hit_d = hit_q;  free_d = free_q;  dfound_d = dfound_q;  stb_d = 1'b0;
    it_d = it_q;  pk_d = pk_q;  pw_d = pw_q;  pd_d = pd_q;  pb_d = pb_q;
    tgt_d = tgt_q;  sidx_d = sidx_q;  hidx_d = hidx_q;  fidx_d = fidx_q;
    lidx_d = lidx_q;  didx_d = didx_q;  lstamp_d = lstamp_q;
    wb_w_d = wb_w_q;  wb_fr_d = wb_fr_q;
    res_d = '0;

    // Compare stage of the entry sweep.
    if (scan_v_q) begin
      if (!hit_q && val_q[sidx_q] && (tag_rd == sec)) begin
        hit_d  = 1'b1;
        hidx_d = sidx_q;
      end
      if (CB'(sidx_q) < lim) begin
        if (!free_q && !val_q[sidx_q]) begin
          free_d = 1'b1;
          fidx_d = sidx_q;
        end
        if ((sidx_q == '0) || (stamp_rd < lstamp_q)) begin
          lidx_d   = sidx_q;
          lstamp_d = stamp_rd;
        end
      end
      if (!dfound_q && val_q[sidx_q] && dty_q[sidx_q]) begin
        dfound_d = 1'b1;
        didx_d   = sidx_q;
      end
    end

    // Output stage of a write-back burst.
    if (wb_v_q) begin
      stb_d               = 1'b1;
      res_d.resp_kind     = RESP_DISK;
      res_d.data_out      = line_rd;
      res_d.disk_sector   = 24'(tag_rd);
      res_d.out_word      = 6'(wb_w_q);
      res_d.last          = wl;
      res_d.fetch_request = wl && wb_fr_q;
      res_d.fetch_sector  = (wl && wb_fr_q) ? 24'(sec) : 24'd0;
    end

    case (op)
      OP_LOAD: begin
        it_d = item_i;  cnt_d = '0;  hit_d = 1'b0;  free_d = 1'b0;  dfound_d = 1'b0;
      end
      OP_SCAN: begin
        if (cnt_q < CB'(CACHE_ENTRIES)) begin
          scan_v_d = 1'b1;
          sidx_d   = cnt_q[EB-1:0];
          cnt_d    = cnt_q + CB'(1);
        end
      end
      OP_ERR: begin
        stb_d = 1'b1;  res_d.resp_kind = RESP_ERROR;  res_d.last = 1'b1;
      end
      OP_FLUSH_ALL: begin
        val_d = '0;  dty_d = '0;
        stb_d = 1'b1;  res_d.resp_kind = RESP_FLUSH;  res_d.last = 1'b1;
      end
      OP_SEL_DIRTY: begin
        tgt_d = didx_q;  wcnt_d = '0;  wb_fr_d = 1'b0;
      end
      OP_SEL_VICTIM: begin
        tgt_d = free_q ? fidx_q : lidx_q;  wcnt_d = '0;  wb_fr_d = 1'b1;
      end
      OP_HIT: begin
        tgt_d = hidx_q;  clk_d = clk_q + 32'd1;
        pk_d = it_q.kind[0];  pw_d = wi;  pd_d = it_q.data_in;  pb_d = it_q.byte_enable;
      end
      OP_ALLOC, OP_ALLOC_FETCH: begin
        val_d[tgt_q] = 1'b0;  dty_d[tgt_q] = 1'b0;  ft_d = tgt_q;  pend_on_d = 1'b1;
        pk_d = it_q.kind[0];  pw_d = wi;  pd_d = it_q.data_in;  pb_d = it_q.byte_enable;
        if (op == OP_ALLOC_FETCH) begin
          stb_d               = 1'b1;
          res_d.resp_kind     = {1'b0, it_q.kind};
          res_d.disk_sector   = 24'(sec);
          res_d.fetch_request = 1'b1;
          res_d.fetch_sector  = 24'(sec);
          res_d.last          = 1'b1;
        end
      end
      OP_CLR_DIRTY: dty_d[tgt_q] = 1'b0;
      OP_WB: begin
        if (wcnt_q < WC'(SECTOR_WORDS)) begin
          wb_v_d = 1'b1;
          wb_w_d = WB'(wcnt_q);
          wcnt_d = wcnt_q + WC'(1);
        end
      end
      OP_FILL_DONE: begin
        pend_on_d = 1'b0;  val_d[ft_q] = 1'b1;  dty_d[ft_q] = 1'b0;
        clk_d = clk_q + 32'd1;  tgt_d = ft_q;
      end
      OP_ACC_DONE: begin
        stb_d = 1'b1;  res_d.last = 1'b1;
        if (pk_q) begin
          res_d.resp_kind = RESP_WRITE;
          if (pb_q != 8'd0) dty_d[tgt_q] = 1'b1;
        end else begin
          res_d.resp_kind = RESP_READ;
          res_d.data_out  = line_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;  dty_q <= '0;  clk_q <= '0;  pend_on_q <= 1'b0;  ft_q <= '0;
      cnt_q <= '0;  scan_v_q <= 1'b0;  wcnt_q <= '0;  wb_v_q <= 1'b0;
      hit_q <= 1'b0;  free_q <= 1'b0;  dfound_q <= 1'b0;  stb_q <= 1'b0;
    end else begin
      val_q <= val_d;  dty_q <= dty_d;  clk_q <= clk_d;  pend_on_q <= pend_on_d;
      ft_q <= ft_d;  cnt_q <= cnt_d;  scan_v_q <= scan_v_d;  wcnt_q <= wcnt_d;
      wb_v_q <= wb_v_d;  hit_q <= hit_d;  free_q <= free_d;  dfound_q <= dfound_d;
      stb_q <= stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d;  pk_q <= pk_d;  pw_q <= pw_d;  pd_q <= pd_d;  pb_q <= pb_d;
    tgt_q <= tgt_d;  sidx_q <= sidx_d;  hidx_q <= hidx_d;  fidx_q <= fidx_d;
    lidx_q <= lidx_d;  didx_q <= didx_d;  lstamp_q <= lstamp_d;
    wb_w_q <= wb_w_d;  wb_fr_q <= wb_fr_d;  res_q <= res_d;
  end

  assign sts_o.kind      = it_q.kind;
  assign sts_o.pend_on   = pend_on_q;
  assign sts_o.oor       = ({1'b0, it_q.sector} >= cfg_i.disk_sectors);
  assign sts_o.scan_done = (cnt_q == CB'(CACHE_ENTRIES)) && !scan_v_q;
  assign sts_o.hit       = hit_q;
  assign sts_o.dfound    = dfound_q;
  assign sts_o.vdirty    = val_q[tgt_q] && dty_q[tgt_q];
  assign sts_o.fill_last = (wi == WB'(SECTOR_WORDS - 1));
  assign sts_o.wb_done   = (wcnt_q == WC'(SECTOR_WORDS)) && !wb_v_q;

  assign result_o     = res_q;
  assign res_strobe_o = stb_q;
endmodule

>>> rtl/sector_buffer_cache_lru_unit.sv
// Top level of the sector buffer cache: register port, sequencer and datapath.
// Depends on scb_pkg, scb_ctrl and scb_dp.
`timescale 1ns / 1ps
// A fully associative write-back cache of disk sectors that takes one command word
// at a time: a word is accepted at a clock edge where start is high and busy is low.
// Busy stays high while the command is worked on; its last result word may sit on
// the ports while busy is still high or in the first idle cycle, at whose end the
// next command can already be accepted. Results appear on result_o for exactly one
// cycle, marked by res_strobe_o; the receiver cannot stall them, so it must capture
// every strobed word. A read or write sweeps the tag and use-stamp RAMs one entry
// per cycle and finds a hit, the lowest free entry and the least recently used
// entry in the same pass. Evicting a dirty entry, or a flush step, streams
// SECTOR_WORDS disk-write words out of the line RAM, one per cycle, and the final
// one carries the fetch request on a miss. Each fill word is written to the line
// RAM as a command of its own, and the fill of the last word of a sector finishes
// the waiting access through the fill-done, access-address and access-use steps.
// Commands other than fills that arrive while a fetch is outstanding, and reads and
// writes of sectors at or above disk_sectors, get a single error word. No clearing
// pass runs after reset: entry valid and dirty flags sit in flip-flops.
module sector_buffer_cache_lru_unit import scb_pkg::*; #(
  parameter int CACHE_ENTRIES    = CACHE_ENTRIES_DEF,
  parameter int SECTOR_WORDS     = SECTOR_WORDS_DEF,
  parameter int SECTOR_ADDR_BITS = SECTOR_ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         item_i,
  output out_t        result_o,
  output logic        res_strobe_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;
  logic wr_en;

  // Register 0 (disk_sectors) sits at byte 0, register 1 (entries_in_use) at byte 4.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (paddr[2] == REG_ENTRIES) begin
        cfg_d.entries_in_use = pwdata[6:0];
      end else begin
        cfg_d.disk_sectors = pwdata[24:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.disk_sectors   <= 25'd16777216;
      cfg_q.entries_in_use <= 7'd64;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign prdata = (paddr[2] == REG_DISK_SECTORS) ? 32'(cfg_q.disk_sectors)
                                                 : 32'(cfg_q.entries_in_use);

  // The sequencer decides the step; the datapath owns all storage.
  scb_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd)
  );

  scb_dp #(
    .CACHE_ENTRIES(CACHE_ENTRIES), .SECTOR_WORDS(SECTOR_WORDS),
    .SECTOR_ADDR_BITS(SECTOR_ADDR_BITS)
  ) u_dp (
    .clk_i, .rst_ni, .item_i, .cfg_i(cfg_q), .cmd_i(cmd), .sts_o(sts),
    .result_o, .res_strobe_o
  );
endmodule
